>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the front, queue and back RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SIHR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SIHR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/sihr_pkg.sv
package sihr_pkg;

    // Built depth of the ring.
    localparam int RING_DEPTH  = 256;
    localparam int SLOT_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    // Effective size 1..RING_DEPTH.
    localparam int EFF_W       = $clog2(RING_DEPTH + 1);

    localparam int CFG_SIZE_W  = 9;
    localparam int STAMP_W     = 64;
    localparam int SEC_W       = 35;
    localparam int XID_W       = 32;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 3;

    // Seconds from nanoseconds: estimate from the upper stamp word with a reciprocal
    // multiply (never above the true quotient, at most FIX_STEPS below it), then
    // correct by comparing the remainder against whole seconds.
    localparam logic [SEC_W-1:0] NS_PER_SEC  = SEC_W'(1_000_000_000);
    localparam logic [31:0]      RECIP_K     = 32'd2305843009;   // floor(2^61 / 1e9)
    localparam int               RECIP_SHIFT = 29;
    localparam int               FIX_STEPS   = 13;
    localparam int               FIX_W       = $clog2(FIX_STEPS + 1);
    localparam logic [SEC_W-1:0] REM_LIM     = SEC_W'(FIX_STEPS + 1) * NS_PER_SEC;
    // Step counter of the ring-size remainder unit.
    localparam int CNT_W       = $clog2(SEC_W + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_RECORD = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_FILL   = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_RECORDED = 3'd0,
        ST_SKIPPED  = 3'd1,
        ST_HIT      = 3'd2,
        ST_NEWER    = 3'd3,
        ST_TOO_OLD  = 3'd4,
        ST_FILLED   = 3'd5
    } t_status;

    typedef struct packed {
        t_op              op;
        logic [SEC_W-1:0] sec;
        logic [XID_W-1:0] xid;
    } t_job;

    typedef struct packed {
        logic [EFF_W-1:0] size;
        logic             fill_en;
    } t_cfg;

endpackage

>>> hw/rtl/sihr_ram.sv
module sihr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/sihr_front.sv
`include "assert_macros.svh"

module sihr_front import sihr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [OP_W-1:0]    i_op,
    input  logic [STAMP_W-1:0] i_stamp,
    input  logic [XID_W-1:0]   i_xid,
    output logic               o_push,
    output t_job               o_job,
    input  logic               i_full
);

    typedef enum logic [5:0] {
        F_IDLE = 6'b000001,
        F_MUL  = 6'b000010,
        F_PROD = 6'b000100,
        F_REM  = 6'b001000,
        F_FIX  = 6'b010000,
        F_PUSH = 6'b100000
    } t_fstate;

    t_fstate                r_state, n_state;
    t_op                    r_op, n_op;
    logic [XID_W-1:0]       r_xid, n_xid;
    logic [STAMP_W-1:0]     r_stamp, n_stamp;
    logic [SEC_W-1:0]       r_quo, n_quo;
    logic [SEC_W-1:0]       r_prod, n_prod;
    logic [SEC_W-1:0]       r_rem, n_rem;

    logic [63:0]            est_full;
    logic [FIX_W-1:0]       fix_cnt;

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_xid    = r_xid;
        n_stamp  = r_stamp;
        n_quo    = r_quo;
        n_prod   = r_prod;
        n_rem    = r_rem;
        est_full = 64'(r_stamp[STAMP_W-1:32]) * 64'(RECIP_K);
        // remainder is below FIX_STEPS + 1 seconds: take the highest step it clears
        fix_cnt  = '0;
        for (int k = 1; k <= FIX_STEPS; k++) begin
            if (r_rem >= SEC_W'(k) * NS_PER_SEC) begin
                fix_cnt = FIX_W'(k);
            end
        end

        unique case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    n_xid = i_xid;
                    unique case (i_op) inside
                        OP_RECORD, OP_LOOKUP: begin
                            n_op    = t_op'(i_op);
                            n_stamp = i_stamp;
                            n_state = F_MUL;
                        end
                        OP_FILL: begin
                            n_op    = OP_FILL;
                            n_state = F_PUSH;
                        end
                        // unknown opcode: drop the beat
                        default: n_state = F_IDLE;
                    endcase
                end
            end
            F_MUL: begin
                n_quo   = est_full[63:RECIP_SHIFT];
                n_state = F_PROD;
            end
            F_PROD: begin
                // the remainder fits in SEC_W bits, so only the low product bits matter
                n_prod  = r_quo * NS_PER_SEC;
                n_state = F_REM;
            end
            F_REM: begin
                n_rem   = r_stamp[SEC_W-1:0] - r_prod;
                n_state = F_FIX;
            end
            F_FIX: begin
                n_quo   = r_quo + SEC_W'(fix_cnt);
                n_state = F_PUSH;
            end
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_op    <= n_op;
        r_xid   <= n_xid;
        r_stamp <= n_stamp;
        r_quo   <= n_quo;
        r_prod  <= n_prod;
        r_rem   <= n_rem;
    end

    assign o_ready   = (r_state == F_IDLE);
    assign o_push    = (r_state == F_PUSH) && !i_full;
    // record rounds up to the next second
    assign o_job.op  = r_op;
    assign o_job.sec = (r_op == OP_RECORD) ? r_quo + 1'b1 : r_quo;
    assign o_job.xid = r_xid;

    `SIHR_ASSERT_IMP(a_rem_rng, i_clk, i_rst_n, r_state == F_FIX, r_rem < REM_LIM, "bad estimate")

endmodule

>>> hw/rtl/sihr_fifo.sv
`include "assert_macros.svh"

module sihr_fifo import sihr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    t_job               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wptr, n_wptr;
    logic [QPTR_W-1:0]  r_rptr, n_rptr;
    logic [QCNT_W-1:0]  r_count, n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    assign o_job   = r_mem[r_rptr];
    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);

    `SIHR_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, i_pop, r_count != '0, "pop from empty queue")
    `SIHR_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, i_push, r_count != QCNT_W'(QUEUE_DEPTH), "push into full queue")

endmodule

>>> hw/rtl/sihr_back.sv
`include "assert_macros.svh"

module sihr_back import sihr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_empty,
    input  t_job                i_job,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [XID_W-1:0]    o_result
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_MOD    = 8'b00000010,
        S_WRHEAD = 8'b00000100,
        S_GAP    = 8'b00001000,
        S_RDREQ  = 8'b00010000,
        S_RDWAIT = 8'b00100000,
        S_FILL   = 8'b01000000,
        S_DONE   = 8'b10000000
    } t_bstate;

    t_bstate             r_state, n_state;
    t_job                r_job, n_job;
    logic [SEC_W-1:0]    r_last, n_last;
    logic [SLOT_W-1:0]   r_head, n_head;
    logic [XID_W-1:0]    r_prev, n_prev;
    logic                r_cap_prev, n_cap_prev;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [EFF_W-1:0]    r_left, n_left;
    logic [EFF_W-1:0]    r_mrem, n_mrem;
    logic [SEC_W-1:0]    r_mdiv, n_mdiv;
    logic [CNT_W-1:0]    r_mcnt, n_mcnt;
    logic [SLOT_W-1:0]   r_idx, n_idx;
    t_status             r_status, n_status;
    logic [XID_W-1:0]    r_result, n_result;
    logic                r_out_valid, n_out_valid;
    t_status             r_out_status, n_out_status;
    logic [XID_W-1:0]    r_out_result, n_out_result;
    logic                r_valid [RING_DEPTH];
    logic                r_rd_vld;

    logic                ram_we;
    logic [SLOT_W-1:0]   ram_waddr;
    logic [XID_W-1:0]    ram_wdata;
    logic                ram_re;
    logic [SLOT_W-1:0]   ram_raddr;
    logic [XID_W-1:0]    ram_rdata;

    logic [EFF_W:0]      m_trial;
    logic [EFF_W:0]      m_next;
    logic [SEC_W-1:0]    gap;
    logic [EFF_W-1:0]    size_m1;
    logic [SLOT_W-1:0]   slot_dec;
    logic [EFF_W-1:0]    head_p1;
    logic [SLOT_W-1:0]   head_next;

    sihr_ram #(
        .WIDTH (XID_W),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        // remainder unit: one dividend bit per cycle against the ring size
        m_trial   = {r_mrem, r_mdiv[SEC_W-1]};
        m_next    = (m_trial >= {1'b0, i_cfg.size}) ? m_trial - {1'b0, i_cfg.size} : m_trial;
        gap       = i_job.sec - r_last;
        size_m1   = i_cfg.size - 1'b1;
        slot_dec  = (r_slot == '0) ? size_m1[SLOT_W-1:0] : r_slot - 1'b1;
        head_p1   = EFF_W'(r_head) + 1'b1;
        head_next = (head_p1 == i_cfg.size) ? '0 : head_p1[SLOT_W-1:0];

        n_state      = r_state;
        n_job        = r_job;
        n_last       = r_last;
        n_head       = r_head;
        n_prev       = r_prev;
        n_cap_prev   = r_cap_prev;
        n_slot       = r_slot;
        n_left       = r_left;
        n_mrem       = r_mrem;
        n_mdiv       = r_mdiv;
        n_mcnt       = r_mcnt;
        n_idx        = r_idx;
        n_status     = r_status;
        n_result     = r_result;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_status = r_out_status;
        n_out_result = r_out_result;
        o_pop        = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = r_slot;
        ram_wdata    = r_prev;
        ram_re       = 1'b0;
        ram_raddr    = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_job = i_job;
                    unique case (i_job.op)
                        OP_RECORD: begin
                            if (r_last >= i_job.sec) begin
                                n_status = ST_SKIPPED;
                                n_result = '0;
                                n_state  = S_DONE;
                            end else begin
                                // clamp the number of slots to write at the ring size
                                n_left     = (gap > SEC_W'(i_cfg.size)) ? i_cfg.size
                                                                         : gap[EFF_W-1:0];
                                n_mrem     = '0;
                                n_mdiv     = i_job.sec;
                                n_mcnt     = CNT_W'(SEC_W);
                                ram_re     = 1'b1;
                                n_cap_prev = 1'b1;
                                n_state    = S_MOD;
                            end
                        end
                        OP_LOOKUP: begin
                            if (i_job.sec > r_last) begin
                                ram_re   = 1'b1;
                                n_status = ST_NEWER;
                                n_state  = S_RDWAIT;
                            end else if ((r_last - i_job.sec) < SEC_W'(i_cfg.size)) begin
                                n_mrem   = '0;
                                n_mdiv   = i_job.sec;
                                n_mcnt   = CNT_W'(SEC_W);
                                n_status = ST_HIT;
                                n_state  = S_MOD;
                            end else begin
                                n_status = ST_TOO_OLD;
                                n_result = '0;
                                n_state  = S_DONE;
                            end
                        end
                        OP_FILL: begin
                            n_status = ST_FILLED;
                            n_result = '0;
                            n_idx    = '0;
                            n_state  = i_cfg.fill_en ? S_FILL : S_DONE;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_MOD: begin
                n_mrem = m_next[EFF_W-1:0];
                n_mdiv = {r_mdiv[SEC_W-2:0], 1'b0};
                n_mcnt = r_mcnt - 1'b1;
                // old head value lands in the cycle after the read in idle
                if (r_cap_prev) begin
                    n_prev     = r_rd_vld ? ram_rdata : '0;
                    n_cap_prev = 1'b0;
                end
                if (r_mcnt == CNT_W'(1)) begin
                    n_slot  = m_next[SLOT_W-1:0];
                    n_state = (r_job.op == OP_RECORD) ? S_WRHEAD : S_RDREQ;
                end
            end
            S_WRHEAD: begin
                ram_we    = 1'b1;
                ram_waddr = r_slot;
                ram_wdata = r_job.xid;
                n_last    = r_job.sec;
                n_head    = r_slot;
                n_slot    = slot_dec;
                n_left    = r_left - 1'b1;
                n_status  = ST_RECORDED;
                n_state   = (r_left == EFF_W'(1)) ? S_RDREQ : S_GAP;
            end
            S_GAP: begin
                // walk backward over skipped seconds
                ram_we    = 1'b1;
                ram_waddr = r_slot;
                ram_wdata = r_prev;
                n_slot    = slot_dec;
                n_left    = r_left - 1'b1;
                if (r_left == EFF_W'(1)) begin
                    n_state = S_RDREQ;
                end
            end
            S_RDREQ: begin
                ram_re    = 1'b1;
                ram_raddr = (r_job.op == OP_RECORD) ? head_next : r_slot;
                n_state   = S_RDWAIT;
            end
            S_RDWAIT: begin
                n_result = r_rd_vld ? ram_rdata : '0;
                n_state  = S_DONE;
            end
            S_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = r_job.xid;
                n_idx     = r_idx + 1'b1;
                if (EFF_W'(r_idx) == size_m1) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_result = r_result;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= '0;
            r_head      <= '0;
            r_cap_prev  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < RING_DEPTH; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            r_state     <= n_state;
            r_last      <= n_last;
            r_head      <= n_head;
            r_cap_prev  <= n_cap_prev;
            r_out_valid <= n_out_valid;
            if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end
        end
        if (ram_re) begin
            r_rd_vld <= r_valid[ram_raddr];
        end
        r_job        <= n_job;
        r_prev       <= n_prev;
        r_slot       <= n_slot;
        r_left       <= n_left;
        r_mrem       <= n_mrem;
        r_mdiv       <= n_mdiv;
        r_mcnt       <= n_mcnt;
        r_idx        <= n_idx;
        r_status     <= n_status;
        r_result     <= n_result;
        r_out_status <= n_out_status;
        r_out_result <= n_out_result;
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;
    assign o_result = r_out_result;

    `SIHR_ASSERT_NXT(a_last_grows, i_clk, i_rst_n, r_state == S_WRHEAD, r_last > $past(r_last), "record did not advance the newest second")
    `SIHR_ASSERT_IMP(a_wr_in_window, i_clk, i_rst_n, ram_we, EFF_W'(ram_waddr) < i_cfg.size, "ring write outside the window")

endmodule

>>> hw/rtl/seconds_indexed_xmin_history_ring.sv
// A record runs the remainder, writes the head slot and one slot per skipped second
//   (up to ring_size - 1) and reads; a window lookup runs the remainder and reads; a
//   newer lookup reads the head; a skipped record or too-old lookup goes straight to
//   the result; fill writes ring_size slots, none when fill is disabled. The back's
//   35-step remainder sets the pace; the front queues beats while the back is busy.
// Reset: synchronous, active low; valid bits clear at once so the ring reads as zero.
module seconds_indexed_xmin_history_ring import sihr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // [63:0] stamp_ns, [95:64] xid_value
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] xid_result
    output logic [2:0]  m_axis_tuser,   // [2:0] status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic REG_RING_SIZE = 1'b0;
    localparam logic REG_FILL_EN   = 1'b1;

    logic [CFG_SIZE_W-1:0] r_ring_size;
    logic                  r_fill_en;
    t_cfg                  cfg;

    logic                  q_push;
    logic                  q_pop;
    logic                  q_full;
    logic                  q_empty;
    t_job                  front_job;
    t_job                  back_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_size <= CFG_SIZE_W'(256);
            r_fill_en   <= 1'b1;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_RING_SIZE: r_ring_size <= pwdata[CFG_SIZE_W-1:0];
                REG_FILL_EN:   r_fill_en   <= pwdata[0];
                default:       r_fill_en   <= r_fill_en;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_RING_SIZE: prdata = {{(32 - CFG_SIZE_W){1'b0}}, r_ring_size};
            REG_FILL_EN:   prdata = {31'b0, r_fill_en};
            default:       prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // clamp ring_size to 1..RING_DEPTH
    always_comb begin
        if (r_ring_size == '0) begin
            cfg.size = EFF_W'(1);
        end else if (32'(r_ring_size) > RING_DEPTH) begin
            cfg.size = EFF_W'(RING_DEPTH);
        end else begin
            cfg.size = EFF_W'(r_ring_size);
        end
        cfg.fill_en = r_fill_en;
    end

    sihr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_op    (s_axis_tuser),
        .i_stamp (s_axis_tdata[63:0]),
        .i_xid   (s_axis_tdata[95:64]),
        .o_push  (q_push),
        .o_job   (front_job),
        .i_full  (q_full)
    );

    sihr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (back_job),
        .o_empty (q_empty)
    );

    sihr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_empty  (q_empty),
        .i_job    (back_job),
        .o_pop    (q_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_status (m_axis_tuser),
        .o_result (m_axis_tdata)
    );

endmodule
